@@ hw/rtl/etur_pkg.sv @@
`timescale 1ns / 1ps

package etur_pkg;

  localparam int WORD_BITS  = 16;
  localparam int TIME_WIDTH = 32;

  localparam int COUNT_W = $clog2(WORD_BITS + 1);
  localparam int IDX_W   = $clog2(WORD_BITS);

  localparam int BIT_TIME_W = 16;
  localparam int DBITS_W    = 4;
  // bit time times (1 + data bits + parity), at most 65535 * 17
  localparam int FACTOR_W   = 5;
  localparam int TIMEOUT_W  = BIT_TIME_W + FACTOR_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY = 2'd2;

  localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST  = 16'd104;
  localparam logic [DBITS_W-1:0]    DATA_BITS_RST = 4'd8;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic [BIT_TIME_W-1:0] divisor;    // bit time, zero taken as one
    logic [DBITS_W-1:0]    data_bits;
    logic [TIMEOUT_W-1:0]  timeout;    // frame length in microseconds
  } cfg_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] diff;
    logic                  ge;
  } alu_res_t;

endpackage

@@ hw/rtl/etur_alu.sv @@
`timescale 1ns / 1ps

// shared subtract and compare unit
module etur_alu (
  input  logic [etur_pkg::TIME_WIDTH-1:0] a,
  input  logic [etur_pkg::TIME_WIDTH-1:0] b,
  output etur_pkg::alu_res_t              res
);
  import etur_pkg::*;

  assign res.diff = a - b;
  assign res.ge   = (a >= b);

endmodule

@@ hw/rtl/etur_cfg.sv @@
`timescale 1ns / 1ps

module etur_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [etur_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etur_pkg::CFG_DATA_W-1:0]  cfg_data,
  output etur_pkg::cfg_t                   cfg
);
  import etur_pkg::*;

  logic [BIT_TIME_W-1:0] bit_time;
  logic [DBITS_W-1:0]    data_bits;
  logic                  parity;
  logic [FACTOR_W-1:0]   factor;
  logic [TIMEOUT_W-1:0]  timeout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time  <= BIT_TIME_RST;
      data_bits <= DATA_BITS_RST;
      parity    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BIT_TIME:  bit_time  <= cfg_data[BIT_TIME_W-1:0];
        REG_DATA_BITS: data_bits <= cfg_data[DBITS_W-1:0];
        REG_PARITY:    parity    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign factor = FACTOR_W'(1) + FACTOR_W'(data_bits) + FACTOR_W'(parity);

  // frame length registered after the multiply
  always_ff @(posedge clk) begin
    timeout <= TIMEOUT_W'(bit_time) * TIMEOUT_W'(factor);
  end

  assign cfg.divisor   = (bit_time == '0) ? BIT_TIME_W'(1) : bit_time;
  assign cfg.data_bits = data_bits;
  assign cfg.timeout   = timeout;

endmodule

@@ hw/rtl/edge_timed_uart_receiver.sv @@
`timescale 1ns / 1ps

// Serial character receiver fed by timestamped line events instead of line samples. Each
// slave transaction is a line edge (tuser 0, tdata carries the time and the level after the
// edge) or a periodic poll (tuser 1, present level). A falling edge while idle opens a frame;
// later edges add floor(elapsed / bit time) bits of the level that held before the edge,
// LSB first. Once (1 + data bits + parity) bit times have passed since the frame start, the
// next event closes the frame: with the line high the character goes out with tuser 0,
// otherwise a zero byte with tuser 1 flags a missing stop bit. An idle event is done in
// the idle state; a frame event passes the frame and compare steps and, save for a poll
// before the timeout, the edge step, a divide step per added bit (at most 16) and one
// more, and the emit step if it closes the frame, as one 32-bit subtract/compare unit
// forms both time differences, checks the timeout and peels off one bit time per cycle;
// new events wait while busy. A finished result waits in an output register, so the next
// event is taken while the master side is stalled; a frame that closes while an earlier
// result still waits holds until that result is taken. Configuration: index 0 bit time in
// microseconds (zero acts as one), 1 data bits, 2 parity present; write only while idle.
module edge_timed_uart_receiver (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [etur_pkg::IN_DATA_W-1:0]    s_tdata,   // time_us [31:0], line_level [32]
  input  logic                              s_tuser,   // command: 0 edge, 1 poll
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [etur_pkg::OUT_DATA_W-1:0]   m_tdata,   // data_byte [7:0]
  output logic                              m_tuser,   // status: 1 stop bit missing
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [etur_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [etur_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import etur_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_FRAME = 3'd1;  // time since frame start
  localparam logic [2:0] S_TCMP  = 3'd2;  // compare against frame length
  localparam logic [2:0] S_EDGE  = 3'd3;  // time since last edge
  localparam logic [2:0] S_DIV   = 3'd4;  // one bit time per cycle
  localparam logic [2:0] S_EMIT  = 3'd5;  // load the output register

  cfg_t     cfg;
  alu_res_t alu;

  logic [2:0]            state;
  logic                  receiving;
  logic [WORD_BITS-1:0]  shift_word;
  logic [COUNT_W-1:0]    bit_count;
  logic [TIME_WIDTH-1:0] frame_start;
  logic [TIME_WIDTH-1:0] last_edge;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] rem;
  logic                  poll;
  logic                  level;
  logic                  timed_out;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_byte;
  logic                  out_status;

  logic [TIME_WIDTH-1:0] alu_a;
  logic [TIME_WIDTH-1:0] alu_b;
  logic                  app_level;
  logic                  div_done;
  logic [COUNT_W-1:0]    keep;
  logic [WORD_BITS:0]    mask_full;
  logic [WORD_BITS-1:0]  char_bits;

  etur_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  etur_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  // operand selection for the shared unit
  always_comb begin
    unique case (state)
      S_FRAME: begin
        alu_a = now;
        alu_b = frame_start;
      end
      S_TCMP: begin
        alu_a = rem;
        alu_b = TIME_WIDTH'(cfg.timeout);
      end
      S_EDGE: begin
        alu_a = now;
        alu_b = last_edge;
      end
      default: begin
        alu_a = rem;
        alu_b = TIME_WIDTH'(cfg.divisor);
      end
    endcase
  end

  // a poll fills with the present level, an edge with the level before it
  assign app_level = poll ? level : ~level;

  // stop when the word is full or less than one bit time remains
  assign div_done = (bit_count == COUNT_W'(WORD_BITS)) || !alu.ge;

  // drop the start bit and keep the data bits
  always_comb begin
    keep = (COUNT_W'(cfg.data_bits) < COUNT_W'(WORD_BITS)) ?
           COUNT_W'(cfg.data_bits) : COUNT_W'(WORD_BITS);
    mask_full = ((WORD_BITS + 1)'(1) << keep) - (WORD_BITS + 1)'(1);
    char_bits = (shift_word >> 1) & mask_full[WORD_BITS-1:0];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tuser  = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      receiving   <= 1'b0;
      out_valid   <= 1'b0;
      shift_word  <= '0;
      bit_count   <= '0;
      frame_start <= '0;
      last_edge   <= '0;
    end else begin
      // the emit step reloads the output register itself
      if (out_valid && m_tready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            poll  <= s_tuser;
            now   <= s_tdata[TIME_WIDTH-1:0];
            level <= s_tdata[TIME_WIDTH];
            if (receiving) begin
              state <= S_FRAME;
            end else if (!s_tuser && !s_tdata[TIME_WIDTH]) begin
              // falling edge opens a frame
              receiving   <= 1'b1;
              shift_word  <= '0;
              bit_count   <= '0;
              frame_start <= s_tdata[TIME_WIDTH-1:0];
              last_edge   <= s_tdata[TIME_WIDTH-1:0];
            end
          end
        end
        S_FRAME: begin
          rem   <= alu.diff;
          state <= S_TCMP;
        end
        S_TCMP: begin
          timed_out <= alu.ge;
          // a poll inside the frame changes nothing
          state     <= (!alu.ge && poll) ? S_IDLE : S_EDGE;
        end
        S_EDGE: begin
          rem   <= alu.diff;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (timed_out) begin
              state <= S_EMIT;
            end else begin
              last_edge <= now;
              state     <= S_IDLE;
            end
          end else begin
            rem                         <= alu.diff;
            shift_word[bit_count[IDX_W-1:0]] <= app_level;
            bit_count                   <= bit_count + COUNT_W'(1);
          end
        end
        S_EMIT: begin
          if (!out_valid || m_tready) begin
            out_valid   <= 1'b1;
            out_byte    <= level ? char_bits[OUT_DATA_W-1:0] : '0;
            out_status  <= ~level;
            receiving   <= 1'b0;
            shift_word  <= '0;
            bit_count   <= '0;
            frame_start <= '0;
            last_edge   <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/etur_checker.sv @@
`timescale 1ns / 1ps

module etur_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [etur_pkg::OUT_DATA_W-1:0]   m_tdata,
  input logic                              m_tuser
);
  import etur_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a framing error carries a zero byte
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("framing error with nonzero byte");

  // a new result comes only out of a busy sequence
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a frame in progress");

endmodule

bind edge_timed_uart_receiver etur_checker u_etur_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import etur_pkg::*;

  // event kinds on the slave tuser, result kinds on the master tuser
  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_POLL    = 1'b1;
  localparam logic ST_CHAR     = 1'b0;
  localparam logic ST_FRAMING  = 1'b1;

  typedef struct packed {
    logic [OUT_DATA_W-1:0] data_byte;
    logic                  status;
  } rx_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;    // time_us [31:0], line_level [32]
  logic                  s_tuser = 1'b0;  // command: 0 edge, 1 poll
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // data_byte [7:0]
  logic                  m_tuser;         // status: 1 stop bit missing
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  edge_timed_uart_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver-side copy of the registers, in step with every accepted write
  logic [BIT_TIME_W-1:0] rx_bit_time  = BIT_TIME_RST;
  logic [DBITS_W-1:0]    rx_data_bits = DATA_BITS_RST;
  logic                  rx_parity    = 1'b0;

  // frame decoder state of the predictor
  bit                    rx_busy  = 1'b0;
  logic [WORD_BITS-1:0]  rx_word  = '0;
  int unsigned           rx_count = 0;
  logic [31:0]           rx_start = '0;
  logic [31:0]           rx_last  = '0;

  rx_result_t            rx_expected_q[$];
  int                    mismatches = 0;
  int                    items_sent = 0;
  logic [31:0]           line_time = '0;   // timestamp of the last event sent
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;

  // frame length in microseconds; a zero bit time gives a zero length
  function automatic logic [31:0] frame_length();
    return 32'(rx_bit_time) * (32'd1 + 32'(rx_data_bits) + 32'(rx_parity));
  endfunction

  // shift in floor(elapsed / bit time) copies of lvl, clipped to the word
  function automatic void append_bits(input logic [31:0] now, input logic lvl);
    logic [31:0] span;
    logic [31:0] div;
    logic [31:0] nbits;
    logic [31:0] fill;
    int unsigned room;
    int unsigned add;
    div   = (rx_bit_time == '0) ? 32'd1 : 32'(rx_bit_time);
    span  = now - rx_last;
    nbits = span / div;
    room  = WORD_BITS - rx_count;
    add   = (nbits < room) ? nbits : room;
    if (lvl && add > 0) begin
      fill = ((32'd1 << add) - 32'd1) << rx_count;
      rx_word = rx_word | fill[WORD_BITS-1:0];
    end
    rx_count = rx_count + add;
  endfunction

  // one accepted event: returns 1 with the character or error it closes
  function automatic bit predict_event(input logic cmd, input logic [31:0] now,
                                       input logic lvl, output rx_result_t res);
    logic [31:0] span;
    logic [WORD_BITS-1:0] keep_mask;
    res = '0;
    if (!rx_busy) begin
      // only a falling edge opens a frame, anything else is dropped
      if (cmd == CMD_EDGE && !lvl) begin
        rx_busy  = 1'b1;
        rx_word  = '0;
        rx_count = 0;
        rx_start = now;
        rx_last  = now;
      end
      return 1'b0;
    end
    span = now - rx_start;
    if (span < frame_length()) begin
      // polls inside a frame carry no information
      if (cmd == CMD_EDGE) begin
        append_bits(now, !lvl);
        rx_last = now;
      end
      return 1'b0;
    end
    // trailing bits: pre-edge level for an edge, present level for a poll
    append_bits(now, (cmd == CMD_POLL) ? lvl : !lvl);
    if (lvl) begin
      keep_mask     = WORD_BITS'((32'd1 << rx_data_bits) - 32'd1);
      res.data_byte = OUT_DATA_W'((rx_word >> 1) & keep_mask);
      res.status    = ST_CHAR;
    end else begin
      res.data_byte = '0;
      res.status    = ST_FRAMING;
    end
    rx_busy  = 1'b0;
    rx_word  = '0;
    rx_count = 0;
    rx_start = '0;
    rx_last  = '0;
    return 1'b1;
  endfunction

  // receiver stalls, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // every master transaction is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (rx_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: data %02h status %0d", m_tdata, m_tuser);
      end else begin
        want = rx_expected_q.pop_front();
        if (m_tdata !== want.data_byte || m_tuser !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected data %02h status %0d, got data %02h status %0d",
                     want.data_byte, want.status, m_tdata, m_tuser);
        end
      end
    end
  end

  // one slave transaction; valid stays up when the next event follows at once
  task automatic send_event(input logic cmd, input logic [31:0] stamp, input logic lvl);
    rx_result_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lvl, stamp};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    if (predict_event(cmd, stamp, lvl, res))
      rx_expected_q.push_back(res);
    items_sent++;
    line_time = stamp;
  endtask

  // sender holds off until every expected result has come out
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (rx_expected_q.size() != 0)
      @(posedge clk);
  endtask

  // force an open frame shut with a poll at or just after its timeout
  task automatic close_open_frame();
    send_event(CMD_POLL, rx_start + frame_length() + 32'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)));
  endtask

  // no frame open, no result pending, and the last event fully worked off
  task automatic settle_block();
    if (rx_busy)
      close_open_frame();
    drain_results();
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BIT_TIME:  rx_bit_time  = value;
      REG_DATA_BITS: rx_data_bits = value[DBITS_W-1:0];
      REG_PARITY:    rx_parity    = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // unused upper bits of the narrow registers get random filler
  task automatic set_config(input logic [15:0] bt, input logic [3:0] db, input logic par);
    settle_block();
    write_register(REG_BIT_TIME, bt);
    write_register(REG_DATA_BITS, (16'($urandom) & 16'hFFF0) | 16'(db));
    write_register(REG_PARITY, (16'($urandom) & 16'hFFFE) | 16'(par));
  endtask

  // line events of one character: falling start edge, an edge at every level
  // change, then either an edge at the timeout or a poll inside the stop bit
  task automatic send_frame(input logic [15:0] pattern, input logic stop_lvl,
                            input logic [31:0] t0, input bit jitter, input bit chatter);
    int unsigned step;
    int unsigned nbits;
    int          k;
    logic        prev;
    logic        cur;
    logic [31:0] stamp;
    if (rx_busy)
      close_open_frame();
    step  = (rx_bit_time == '0) ? 1 : rx_bit_time;
    nbits = 1 + rx_data_bits + rx_parity;
    send_event(CMD_EDGE, t0, 1'b0);
    prev = 1'b0;
    for (k = 1; k <= nbits; k++) begin
      if (k == nbits)
        cur = stop_lvl;
      else if (k <= rx_data_bits)
        cur = pattern[k-1];
      else
        cur = 1'($urandom_range(0, 1));  // parity slot, not checked
      stamp = t0 + k * step + (jitter ? $urandom_range(0, step / 4) : 0);
      // polls before the timeout must leave the frame alone
      if (chatter && k < nbits && $urandom_range(0, 2) == 0)
        send_event(CMD_POLL, stamp, prev);
      if (cur != prev)
        send_event(CMD_EDGE, stamp, cur);
      else if (k == nbits)
        send_event(CMD_POLL, stamp + $urandom_range(0, step / 2), cur);
      prev = cur;
    end
  endtask

  // stray event near the present time, or anywhere on the time axis
  task automatic send_noise();
    logic [31:0] stamp;
    int unsigned step;
    step = (rx_bit_time == '0) ? 1 : rx_bit_time;
    if ($urandom_range(0, 7) == 0)
      stamp = $urandom;
    else
      stamp = line_time + $urandom_range(0, frame_length() + 2 * step);
    send_event(1'($urandom_range(0, 1)), stamp, 1'($urandom_range(0, 1)));
  endtask

  task automatic randomize_config();
    logic [15:0] bt;
    logic [3:0]  db;
    case ($urandom_range(0, 15))
      0:       bt = 16'd0;
      1:       bt = 16'd1;
      2, 3:    bt = 16'd65535;
      4, 5:    bt = 16'd104;
      6, 7, 8: bt = 16'($urandom_range(2, 20));
      default: bt = 16'($urandom_range(1, 65535));
    endcase
    // mostly legal character sizes, now and then any 4-bit value
    if ($urandom_range(0, 5) == 0)
      db = 4'($urandom_range(0, 15));
    else
      db = 4'($urandom_range(5, 8));
    set_config(bt, db, 1'($urandom_range(0, 1)));
  endtask

  // reset configuration: 104 us bits, 8 data bits, no parity
  task automatic test_directed_cases();
    send_event(CMD_POLL, 32'd500, 1'b1);            // poll while idle
    send_event(CMD_EDGE, 32'd600, 1'b1);            // rising edge while idle
    send_frame(16'h0000, 1'b1, 32'd1000, 0, 0);     // stop edge lands on the timeout
    send_frame(16'h00FF, 1'b1, 32'd3000, 0, 0);     // closed by a poll
    send_frame(16'h00A5, 1'b1, 32'd5000, 0, 1);     // polls in between
    send_frame(16'h0080, 1'b0, 32'd8000, 0, 0);     // falling edge at timeout: error
    send_event(CMD_EDGE, 32'd9500, 1'b1);           // line recovers while idle
    // poll inside the frame, then a poll at the timeout with the line low
    send_event(CMD_EDGE, 32'd10000, 1'b0);
    send_event(CMD_POLL, 32'd10300, 1'b0);
    send_event(CMD_POLL, 32'd10936, 1'b0);
    send_frame(16'h003C, 1'b1, 32'hFFFF_FF80, 0, 0);  // timestamps wrap mid frame
  endtask

  task automatic test_register_extremes();
    set_config(16'd1, 4'd5, 1'b0);
    send_frame(16'h0015, 1'b1, 32'd20000, 0, 0);
    send_frame(16'h001F, 1'b1, 32'd20100, 0, 0);
    // 17 bit times per frame: the word fills and the count saturates
    set_config(16'd65535, 4'd15, 1'b1);
    send_frame(16'h7FFF, 1'b1, 32'hFFF0_0000, 0, 0);
    send_frame(16'h1234, 1'b1, 32'd40000, 1, 0);
    // zero bit time acts as one microsecond, the timeout collapses to zero
    set_config(16'd0, 4'd8, 1'b0);
    send_frame(16'h005A, 1'b1, 32'd90000, 0, 0);
    send_noise();
    set_config(16'd3, 4'd0, 1'b1);
    send_frame(16'h0000, 1'b1, 32'd95000, 0, 0);
    set_config(BIT_TIME_RST, DATA_BITS_RST, 1'b0);
    send_frame(16'h00C3, 1'b1, 32'd99000, 1, 1);
  endtask

  // mostly well-formed characters with random content, a quarter stray events
  task automatic test_random_traffic(input int count);
    int          phase_start;
    int          next_cfg;
    int unsigned step;
    logic [31:0] t0;
    phase_start = items_sent;
    next_cfg    = 0;
    while (items_sent - phase_start < count) begin
      if (items_sent - phase_start >= next_cfg) begin
        randomize_config();
        next_cfg = next_cfg + 60 + $urandom_range(0, 60);
      end
      step = (rx_bit_time == '0) ? 1 : rx_bit_time;
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 9) == 0)
          t0 = $urandom;
        else
          t0 = line_time + $urandom_range(1, 3 * step);
        send_frame(16'($urandom), $urandom_range(0, 9) != 0, t0,
                   1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 26;
    recv_idle_pct = 64;
    test_directed_cases();
    test_register_extremes();
    test_random_traffic(270);

    send_idle_pct = 64;
    recv_idle_pct = 26;
    test_random_traffic(270);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(260);

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && rx_expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // a correct run needs well under a tenth of this
  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/etur_pkg.sv
hw/rtl/etur_alu.sv
hw/rtl/etur_cfg.sv
hw/rtl/edge_timed_uart_receiver.sv
hw/rtl/etur_checker.sv
test/tb_top.sv
